FILE: design/hasm_pkg.sv
// Shared types, constants and weight function for the stereo mixer.
package hasm_pkg;

  // Default sample width and fixed field widths.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LANES           = 6;
  localparam int TONE_LANES      = 4;
  localparam int W_BITS          = 11;
  localparam int OUT_BITS        = 17;
  localparam int BIAS_BITS       = 10;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_IDX_BITS    = 2;

  // Register reset images.
  localparam logic [7:0]  NR50_RST = 8'h77;
  localparam logic [7:0]  NR51_RST = 8'hFF;
  localparam logic [15:0] MIXC_RST = 16'h210E;
  localparam logic [15:0] BIAS_RST = 16'h0200;

  // FIFO voice weights (twice the nominal 256 and 512).
  localparam logic [W_BITS-1:0] FIFO_W_HALF = W_BITS'(512);
  localparam logic [W_BITS-1:0] FIFO_W_FULL = W_BITS'(1024);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NR50 = 2'd0,
    CFG_NR51 = 2'd1,
    CFG_MIXC = 2'd2,
    CFG_BIAS = 2'd3
  } cfg_idx_e;

  // Stage enables handed from the pipeline control to a merge unit.
  typedef struct packed {
    logic en_sum;
    logic en_clamp;
    logic en_out;
  } stage_en_t;

  // Twice the tone weight: (240 * (master volume + 1)) >> (4 - volume code).
  function automatic logic [W_BITS-1:0] tone_weight(input logic [2:0] mvol,
                                                   input logic [1:0] code);
    logic [W_BITS-1:0] full;
    logic [W_BITS-1:0] res;
    full = W_BITS'(240) * W_BITS'({1'b0, mvol} + 4'd1);
    unique case (code)
      2'd0: res = full >> 4;
      2'd1: res = full >> 3;
      2'd2: res = full >> 2;
      2'd3: res = full >> 1;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/hasm_in_if.sv
// Input channel: one frame of six voice samples and a block-end flag.
interface hasm_in_if #(
  parameter int SAMPLE_BITS = hasm_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] square1_sample;
  logic signed [SAMPLE_BITS-1:0] square2_sample;
  logic signed [SAMPLE_BITS-1:0] wave_sample;
  logic signed [SAMPLE_BITS-1:0] noise_sample;
  logic signed [SAMPLE_BITS-1:0] fifo_a_sample;
  logic signed [SAMPLE_BITS-1:0] fifo_b_sample;
  logic                          block_end;

  modport source (
    output valid, square1_sample, square2_sample, wave_sample, noise_sample,
           fifo_a_sample, fifo_b_sample, block_end,
    input  ready
  );

  modport sink (
    input  valid, square1_sample, square2_sample, wave_sample, noise_sample,
           fifo_a_sample, fifo_b_sample, block_end,
    output ready
  );
endinterface

FILE: design/hasm_out_if.sv
// Output channel: one mixed stereo sample pair and the block-done flag.
interface hasm_out_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [hasm_pkg::OUT_BITS-1:0] left_out;
  logic signed [hasm_pkg::OUT_BITS-1:0] right_out;
  logic                                 block_done;

  modport source (
    output valid, left_out, right_out, block_done,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out, block_done,
    output ready
  );
endinterface

FILE: design/handheld_audio_stereo_mixer.sv
// Top level of the stereo mixer: register file, voice lanes, merge units and flow control.
//
//   Channel   Direction  Handshake      Carries
//   in_i      sink       valid/ready    six voice samples, block_end
//   out_o     source     valid/ready    left_out, right_out, block_done
//   cfg       write      cfg_we_i       register index and 16-bit data
//
// One frame is taken per cycle while the input is not stalled; each frame passes through
// four register stages: lane multiply, lane sum, bias clamp, scale and output.
// Each stage holds one frame and moves on whenever the next stage is free, so
// a stalled output only blocks input once all four stages are full.
// Reset clears the stage valid bits and loads the register reset images.
module handheld_audio_stereo_mixer #(
  parameter int SAMPLE_BITS = hasm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  hasm_in_if.sink                               in_i,
  hasm_out_if.source                            out_o,
  input  logic                                  cfg_we_i,
  input  logic [hasm_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [hasm_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import hasm_pkg::*;

  localparam int PW = SAMPLE_BITS + W_BITS + 1;

  logic [7:0]  nr50_q, nr51_q;
  logic [15:0] mixc_q, bias_q;

  // Register file; the sampling-cycle bits are stored but unused.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr50_q <= NR50_RST;
      nr51_q <= NR51_RST;
      mixc_q <= MIXC_RST;
      bias_q <= BIAS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NR50: nr50_q <= cfg_data_i[7:0];
        CFG_NR51: nr51_q <= cfg_data_i[7:0];
        CFG_MIXC: mixc_q <= cfg_data_i;
        CFG_BIAS: bias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-lane weights for each side; zero where a voice is not routed.
  logic [W_BITS-1:0] tone_l, tone_r, fifo_a_w, fifo_b_w;
  logic [W_BITS-1:0] w_left [LANES];
  logic [W_BITS-1:0] w_right [LANES];

  assign tone_l   = tone_weight(nr50_q[6:4], mixc_q[1:0]);
  assign tone_r   = tone_weight(nr50_q[2:0], mixc_q[1:0]);
  assign fifo_a_w = mixc_q[2] ? FIFO_W_FULL : FIFO_W_HALF;
  assign fifo_b_w = mixc_q[3] ? FIFO_W_FULL : FIFO_W_HALF;

  always_comb begin
    for (int i = 0; i < TONE_LANES; i++) begin
      w_left[i]  = nr51_q[TONE_LANES + i] ? tone_l : '0;
      w_right[i] = nr51_q[i] ? tone_r : '0;
    end
    w_left[4]  = mixc_q[9]  ? fifo_a_w : '0;
    w_right[4] = mixc_q[8]  ? fifo_a_w : '0;
    w_left[5]  = mixc_q[13] ? fifo_b_w : '0;
    w_right[5] = mixc_q[12] ? fifo_b_w : '0;
  end

  // Stage flow control: a stage loads when it is empty or its frame moves on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic f1, f2, f3, f4;

  assign f4 = !v4_q || out_o.ready;
  assign f3 = !v3_q || f4;
  assign f2 = !v2_q || f3;
  assign f1 = !v1_q || f2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (f1) v1_q <= in_i.valid;
      if (f2) v2_q <= v1_q;
      if (f3) v3_q <= v2_q;
      if (f4) v4_q <= v3_q;
    end
  end

  // The block-end flag travels beside the frame.
  logic be1_q, be2_q, be3_q, be4_q;

  always_ff @(posedge clk_i) begin
    if (f1) be1_q <= in_i.block_end;
    if (f2) be2_q <= be1_q;
    if (f3) be3_q <= be2_q;
    if (f4) be4_q <= be3_q;
  end

  // Voice lanes.
  logic signed [SAMPLE_BITS-1:0] samp [LANES];
  logic signed [PW-1:0] prod_l [LANES];
  logic signed [PW-1:0] prod_r [LANES];

  assign samp[0] = in_i.square1_sample;
  assign samp[1] = in_i.square2_sample;
  assign samp[2] = in_i.wave_sample;
  assign samp[3] = in_i.noise_sample;
  assign samp[4] = in_i.fifo_a_sample;
  assign samp[5] = in_i.fifo_b_sample;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    hasm_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .en_i         (f1),
      .sample_i     (samp[g]),
      .w_left_i     (w_left[g]),
      .w_right_i    (w_right[g]),
      .prod_left_o  (prod_l[g]),
      .prod_right_o (prod_r[g])
    );
  end

  // One merge unit for each side.
  stage_en_t stage_en;
  logic signed [OUT_BITS-1:0] left_res, right_res;

  assign stage_en.en_sum   = f2;
  assign stage_en.en_clamp = f3;
  assign stage_en.en_out   = f4;

  hasm_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge_left (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .prod_i (prod_l),
    .bias_i (bias_q[BIAS_BITS-1:0]),
    .res_o  (left_res)
  );

  hasm_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge_right (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .prod_i (prod_r),
    .bias_i (bias_q[BIAS_BITS-1:0]),
    .res_o  (right_res)
  );

  // Channel outputs.
  assign in_i.ready       = f1;
  assign out_o.valid      = v4_q;
  assign out_o.left_out   = left_res;
  assign out_o.right_out  = right_res;
  assign out_o.block_done = be4_q;

  // Input is refused only when the whole pipeline is backed up from the output.
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  // A new result only appears after a frame reached the clamp stage.
  a_out_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(v3_q))
    else $error("result appeared with no frame behind it");

  // Clamped results stay within the scaled DAC range on both sides.
  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.left_out >= -17'sd49104 && out_o.left_out <= 17'sd49104
                     && out_o.right_out >= -17'sd49104
                     && out_o.right_out <= 17'sd49104))
    else $error("mixed sample outside clamp range");
endmodule

FILE: design/hasm_lane.sv
// One voice lane: weights a sample for the left and right sides and registers both.
module hasm_lane #(
  parameter int SAMPLE_BITS = hasm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [SAMPLE_BITS-1:0]           sample_i,
  input  logic [hasm_pkg::W_BITS-1:0]             w_left_i,
  input  logic [hasm_pkg::W_BITS-1:0]             w_right_i,
  output logic signed [SAMPLE_BITS+hasm_pkg::W_BITS:0] prod_left_o,
  output logic signed [SAMPLE_BITS+hasm_pkg::W_BITS:0] prod_right_o
);
  import hasm_pkg::*;

  localparam int PW = SAMPLE_BITS + W_BITS + 1;

  logic signed [PW-1:0] prod_left_d, prod_right_d;
  logic signed [PW-1:0] prod_left_q, prod_right_q;

  // A weight of zero means the voice is not routed to that side.
  assign prod_left_d  = sample_i * $signed({1'b0, w_left_i});
  assign prod_right_d = sample_i * $signed({1'b0, w_right_i});

  // Product registers, loaded whenever this stage is free.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_left_q  <= prod_left_d;
      prod_right_q <= prod_right_d;
    end
  end

  assign prod_left_o  = prod_left_q;
  assign prod_right_o = prod_right_q;
endmodule

FILE: design/hasm_merge.sv
// Merge unit for one side: sums the lanes, applies the bias clamp and scales by 48.
module hasm_merge #(
  parameter int SAMPLE_BITS = hasm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  hasm_pkg::stage_en_t                          en_i,
  input  logic signed [SAMPLE_BITS+hasm_pkg::W_BITS:0] prod_i [hasm_pkg::LANES],
  input  logic [hasm_pkg::BIAS_BITS-1:0]               bias_i,
  output logic signed [hasm_pkg::OUT_BITS-1:0]         res_o
);
  import hasm_pkg::*;

  localparam int PW = SAMPLE_BITS + W_BITS + 1;
  localparam int SW = SAMPLE_BITS + 14;
  localparam int DW = SAMPLE_BITS + 12;
  localparam int MW = SAMPLE_BITS + 18;
  localparam logic signed [SW-1:0] ACC_LIM = SW'(1024) << SAMPLE_BITS;
  localparam logic signed [MW-1:0] RND     = MW'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic signed [SW-1:0] sum_d, sum_q;
  logic signed [SW-1:0] bias_sh, acc;
  logic signed [SW-1:0] hi_d;
  logic signed [DW-1:0] dif_d, dif_q;
  logic signed [MW-1:0] dif_ext, scaled, adj, shr;
  logic signed [OUT_BITS-1:0] res_d, res_q;

  // Lane products are independent, so they add in one tree.
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_d = sum_d + SW'(prod_i[i]);
    end
  end

  // Bias clamp: the biased sum is kept in 0..1023 and the bias taken off again.
  assign bias_sh = $signed(SW'(bias_i)) <<< SAMPLE_BITS;
  assign acc     = sum_q + bias_sh;
  assign hi_d    = (ACC_LIM - (SW'(1) << SAMPLE_BITS)) - bias_sh;

  always_comb begin
    if (acc >= ACC_LIM) begin
      dif_d = DW'(hi_d);
    end else if (acc < 0) begin
      dif_d = DW'(-bias_sh);
    end else begin
      dif_d = DW'(sum_q);
    end
  end

  // Times 48 as two shifts, then divide by the sample scale rounding toward zero.
  assign dif_ext = MW'(dif_q);
  assign scaled  = (dif_ext <<< 5) + (dif_ext <<< 4);
  assign adj     = scaled[MW-1] ? (scaled + RND) : scaled;
  assign shr     = adj >>> SAMPLE_BITS;
  assign res_d   = shr[OUT_BITS-1:0];

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (en_i.en_sum) begin
      sum_q <= sum_d;
    end
    if (en_i.en_clamp) begin
      dif_q <= dif_d;
    end
    if (en_i.en_out) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule
